[rtl/opds_pkg.sv]
// Package for the ordering permutation delta search core: widths, command codes,
// permutation table and the front-to-back queue entry type. No dependencies.
package opds_pkg;

    localparam int NodeW  = 18;
    localparam int Nodes  = 262144;
    localparam int WeightW = 32;
    localparam int ScoreW = 48;
    localparam int Perms  = 24;
    localparam int Slots  = 4;
    localparam int PermW  = 5;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_SCORE  = 3'd1,
        CMD_SELECT = 3'd2,
        CMD_TRIAL  = 3'd3,
        CMD_FINISH = 3'd4,
        CMD_READ   = 3'd5,
        CMD_NOP6   = 3'd6,
        CMD_NOP7   = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [NodeW-1:0]   node_from;
        logic [NodeW-1:0]   node_to;
        logic [NodeW-1:0]   position;
        logic [1:0]         slot;
        logic [WeightW-1:0] edge_weight;
    } t_item;

    // Slot that lands at position i for permutation k (swap-recursive order).
    function automatic logic [1:0] perm_slot(input logic [PermW-1:0] k, input logic [1:0] i);
        logic [7:0] row;
        begin
            case (k)
                5'd0:  row = 8'b11_10_01_00;
                5'd1:  row = 8'b10_11_01_00;
                5'd2:  row = 8'b11_01_10_00;
                5'd3:  row = 8'b01_11_10_00;
                5'd4:  row = 8'b01_10_11_00;
                5'd5:  row = 8'b10_01_11_00;
                5'd6:  row = 8'b11_10_00_01;
                5'd7:  row = 8'b10_11_00_01;
                5'd8:  row = 8'b11_00_10_01;
                5'd9:  row = 8'b00_11_10_01;
                5'd10: row = 8'b00_10_11_01;
                5'd11: row = 8'b10_00_11_01;
                5'd12: row = 8'b11_00_01_10;
                5'd13: row = 8'b00_11_01_10;
                5'd14: row = 8'b11_01_00_10;
                5'd15: row = 8'b01_11_00_10;
                5'd16: row = 8'b01_00_11_10;
                5'd17: row = 8'b00_01_11_10;
                5'd18: row = 8'b00_10_01_11;
                5'd19: row = 8'b10_00_01_11;
                5'd20: row = 8'b00_01_10_11;
                5'd21: row = 8'b01_00_10_11;
                5'd22: row = 8'b01_10_00_11;
                5'd23: row = 8'b10_01_00_11;
                default: row = 8'b11_10_01_00;
            endcase
            perm_slot = row[2*i +: 2];
        end
    endfunction

endpackage

[rtl/ordering_permutation_delta_search_core.sv]
// An accepted item passes the queue hop, table read, execute and output steps in order;
// finish adds a search over the accumulators and, on an improvement, a commit of the slots.
// The back part takes a new item only after it has put out the result of the last one;
// a waiting result that is not popped stalls the back part.
// Reset: synchronous active-low i_rst_n clears queues, slots, accumulators, score.
// The position table is not cleared; unwritten entries read undefined.
module ordering_permutation_delta_search_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [2:0]                        i_cmd,
    input  logic [opds_pkg::NodeW-1:0]        i_node_from,
    input  logic [opds_pkg::NodeW-1:0]        i_node_to,
    input  logic [opds_pkg::NodeW-1:0]        i_position,
    input  logic [1:0]                        i_slot,
    input  logic [opds_pkg::WeightW-1:0]      i_edge_weight,
    output logic                              empty,
    input  logic                              pop,
    output logic [opds_pkg::ScoreW-1:0]       o_score,
    output logic signed [opds_pkg::ScoreW-1:0] o_delta,
    output logic [opds_pkg::PermW-1:0]        o_perm_index,
    output logic                              o_improved,
    output logic [opds_pkg::NodeW-1:0]        o_position_out
);
    opds_pkg::t_item in_item, q_item;
    logic            q_valid, q_take;

    assign in_item = '{cmd: opds_pkg::t_cmd'(i_cmd), node_from: i_node_from,
                       node_to: i_node_to, position: i_position, slot: i_slot,
                       edge_weight: i_edge_weight};

    opds_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(in_item), .o_valid(q_valid), .o_item(q_item), .i_take(q_take)
    );

    opds_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_take(q_take), .o_empty(empty), .i_pop(pop), .o_score(o_score),
        .o_delta(o_delta), .o_perm_index(o_perm_index), .o_improved(o_improved),
        .o_position_out(o_position_out)
    );
endmodule

[rtl/opds_front.sv]
// Front part: accepts items and holds them in a short queue for the back part.
// Depends on opds_pkg.
module opds_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  opds_pkg::t_item i_item,
    output logic            o_valid,
    output opds_pkg::t_item o_item,
    input  logic            i_take
);
    // two-entry queue storage
    opds_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    // store item
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !wr) |=> r_cnt == 2'd0)
        else $error("queue count rose without a write");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !rd) |=> o_full)
        else $error("full dropped without a read");
endmodule

[rtl/opds_back.sv]
// Back part: position table, slots, 24 accumulators, score, commit sequencer, result register.
// Depends on opds_pkg.
module opds_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  opds_pkg::t_item                  i_item,
    output logic                             o_take,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [opds_pkg::ScoreW-1:0]      o_score,
    output logic signed [opds_pkg::ScoreW-1:0] o_delta,
    output logic [opds_pkg::PermW-1:0]       o_perm_index,
    output logic                             o_improved,
    output logic [opds_pkg::NodeW-1:0]       o_position_out
);
    localparam int NW = opds_pkg::NodeW;
    localparam int SW = opds_pkg::ScoreW;
    localparam logic signed [SW-1:0] AccMax = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] AccMin = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_SEARCH, ST_COMMIT, ST_OUT
    } t_state;

    logic [NW-1:0] r_table [opds_pkg::Nodes];
    logic [NW-1:0] r_rd_a, r_rd_b;

    t_state                    r_state;
    opds_pkg::t_item           r_item;
    logic [NW-1:0]             r_snode [opds_pkg::Slots];
    logic [NW-1:0]             r_spos  [opds_pkg::Slots];
    logic signed [SW-1:0]      r_acc   [opds_pkg::Perms];
    logic [SW-1:0]             r_score;
    logic [opds_pkg::PermW-1:0] r_k;
    logic [1:0]                r_wi;

    logic signed [SW-1:0]      r_res_delta;
    logic [opds_pkg::PermW-1:0] r_res_perm;
    logic                      r_res_impr;
    logic [NW-1:0]             r_res_pos;

    logic [SW-1:0]             r_o_score;
    logic signed [SW-1:0]      r_o_delta;
    logic [opds_pkg::PermW-1:0] r_o_perm;
    logic                      r_o_impr;
    logic [NW-1:0]             r_o_pos;
    logic                      r_o_full;

    logic [SW:0]               sum_w, sum_d;
    logic [NW-1:0]             wr_node;

    assign o_take        = (r_state == ST_IDLE) && i_valid;
    assign o_empty       = !r_o_full;
    assign o_score       = r_o_score;
    assign o_delta       = r_o_delta;
    assign o_perm_index  = r_o_perm;
    assign o_improved    = r_o_impr;
    assign o_position_out = r_o_pos;

    assign sum_w   = {1'b0, r_score} + {{(SW-opds_pkg::WeightW+1){1'b0}}, r_item.edge_weight};
    assign sum_d   = {1'b0, r_score} + {1'b0, r_acc[r_k]};
    assign wr_node = r_snode[opds_pkg::perm_slot(r_k, r_wi)];

    // table read ports, registered
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_table[r_item.node_from];
        r_rd_b <= r_table[r_item.node_to];
        if (r_state == ST_EXEC && r_item.cmd == opds_pkg::CMD_LOAD)
            r_table[r_item.node_from] <= r_item.position;
        else if (r_state == ST_COMMIT)
            r_table[wr_node] <= r_spos[r_wi];
    end

    // trial position of node under permutation k
    function automatic logic [NW-1:0] trial(input logic [opds_pkg::PermW-1:0] k,
                                            input logic [NW-1:0] nd, input logic [NW-1:0] p);
        logic [NW-1:0] t;
        begin
            t = p;
            for (int i = 0; i < opds_pkg::Slots; i++)
                if (r_snode[opds_pkg::perm_slot(k, 2'(i))] == nd) t = r_spos[i];
            trial = t;
        end
    endfunction

    // sequence item processing and hold state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_score  <= '0;
            r_o_full <= 1'b0;
            r_k      <= '0;
            r_wi     <= '0;
            for (int s = 0; s < opds_pkg::Slots; s++) begin
                r_snode[s] <= '0;
                r_spos[s]  <= '0;
            end
            for (int k = 0; k < opds_pkg::Perms; k++) r_acc[k] <= '0;
        end else begin
            // drop the taken result unless a new one is loaded in the same cycle
            if (i_pop && r_o_full && r_state != ST_OUT) r_o_full <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_item  <= i_item;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_EXEC;
                ST_EXEC: begin
                    r_res_delta <= '0;
                    r_res_perm  <= '0;
                    r_res_impr  <= 1'b0;
                    r_res_pos   <= '0;
                    r_state     <= ST_OUT;
                    case (r_item.cmd)
                        opds_pkg::CMD_SCORE: begin
                            if (r_rd_a < r_rd_b)
                                r_score <= sum_w[SW] ? {SW{1'b1}} : sum_w[SW-1:0];
                        end
                        opds_pkg::CMD_SELECT: begin
                            r_snode[r_item.slot] <= r_item.node_from;
                            r_spos[r_item.slot]  <= r_rd_a;
                        end
                        opds_pkg::CMD_TRIAL: begin
                            for (int k = 0; k < opds_pkg::Perms; k++) begin
                                logic nf, of;
                                logic signed [SW:0] a;
                                of = r_rd_a < r_rd_b;
                                nf = trial(5'(k), r_item.node_from, r_rd_a)
                                   < trial(5'(k), r_item.node_to, r_rd_b);
                                a = {r_acc[k][SW-1], r_acc[k]};
                                if (nf && !of) a = a + $signed({17'd0, r_item.edge_weight});
                                else if (!nf && of) a = a - $signed({17'd0, r_item.edge_weight});
                                if (a > $signed({AccMax[SW-1], AccMax})) r_acc[k] <= AccMax;
                                else if (a < $signed({AccMin[SW-1], AccMin})) r_acc[k] <= AccMin;
                                else r_acc[k] <= a[SW-1:0];
                            end
                        end
                        opds_pkg::CMD_FINISH: begin
                            r_k     <= '0;
                            r_state <= ST_SEARCH;
                        end
                        opds_pkg::CMD_READ: r_res_pos <= r_rd_a;
                        default: ;
                    endcase
                end
                ST_SEARCH: begin
                    // scan accumulators in order, one per cycle
                    if (!r_acc[r_k][SW-1] && r_acc[r_k] != '0) begin
                        r_res_delta <= r_acc[r_k];
                        r_res_perm  <= r_k;
                        r_res_impr  <= 1'b1;
                        r_score     <= sum_d[SW] ? {SW{1'b1}} : sum_d[SW-1:0];
                        r_wi        <= '0;
                        r_state     <= ST_COMMIT;
                    end else if (r_k == 5'(opds_pkg::Perms - 1)) begin
                        for (int k = 0; k < opds_pkg::Perms; k++) r_acc[k] <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_k <= r_k + 5'd1;
                    end
                end
                ST_COMMIT: begin
                    // one table write per cycle, position order
                    r_wi <= r_wi + 2'd1;
                    if (r_wi == 2'd3) begin
                        for (int k = 0; k < opds_pkg::Perms; k++) r_acc[k] <= '0;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the result register is free or being taken
                    if (!r_o_full || i_pop) begin
                        r_o_score <= r_score;
                        r_o_delta <= r_res_delta;
                        r_o_perm  <= r_res_perm;
                        r_o_impr  <= r_res_impr;
                        r_o_pos   <= r_res_pos;
                        r_o_full  <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_impr_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_improved) |-> (!o_delta[SW-1] && o_delta != '0))
        else $error("improved result without positive delta");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_state == ST_READ)
        else $error("take did not start processing");
    a_perm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k < 5'(opds_pkg::Perms))
        else $error("permutation index out of range");
endmodule
